>>> hdl/ogce_pkg.sv
// ============================================================================
// ogce_pkg
// Shared types, opcodes and the register setup table of the OLED graphics
// command encoder.
// ============================================================================
package ogce_pkg;

  localparam int SCREEN_WIDTH_DEF  = 96;
  localparam int SCREEN_HEIGHT_DEF = 64;

  localparam int INIT_LEN = 37;
  localparam int IDX_W    = $clog2(INIT_LEN);

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_LINE  = 3'd1,
    OP_RECT  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_PIXEL = 3'd4
  } op_t;

  localparam logic [7:0] CMD_LINE     = 8'h21;
  localparam logic [7:0] CMD_RECT     = 8'h22;
  localparam logic [7:0] CMD_CLEAR    = 8'h25;
  localparam logic [7:0] CMD_FILL     = 8'h26;
  localparam logic [7:0] FILL_ENABLE  = 8'h01;
  localparam logic [7:0] CMD_COL_ADDR = 8'h15;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h75;

  localparam logic [IDX_W-1:0] LINE_LEN  = IDX_W'(8);
  localparam logic [IDX_W-1:0] RECT_LEN  = IDX_W'(13);
  localparam logic [IDX_W-1:0] CLEAR_LEN = IDX_W'(5);
  localparam logic [IDX_W-1:0] PIXEL_LEN = IDX_W'(8);

  localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{
    8'hAE, 8'hA0, 8'h72, 8'hA1, 8'h00, 8'hA2, 8'h00, 8'hA4, 8'hA8, 8'h3F,
    8'hAD, 8'h8E, 8'hB0, 8'h0B, 8'hB1, 8'h31, 8'hB3, 8'hF0, 8'h8A, 8'h64,
    8'h8B, 8'h78, 8'h8C, 8'h64, 8'hBB, 8'h3A, 8'hBE, 8'h3E, 8'h87, 8'h06,
    8'h81, 8'h91, 8'h82, 8'h50, 8'h83, 8'h7D, 8'hAF
  };

  typedef struct packed {
    op_t              op;
    logic [7:0]       c0;
    logic [7:0]       r0;
    logic [7:0]       c1;
    logic [7:0]       r1;
    logic [15:0]      pen;
    logic [15:0]      fill;
    logic [IDX_W-1:0] len;
  } req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } byte_t;

  function automatic logic [7:0] colour_red(input logic [15:0] c);
    return {2'b00, c[15:11], 1'b0};
  endfunction

  function automatic logic [7:0] colour_green(input logic [15:0] c);
    return {2'b00, c[10:5]};
  endfunction

  function automatic logic [7:0] colour_blue(input logic [15:0] c);
    return {2'b00, c[4:0], 1'b0};
  endfunction

endpackage

>>> hdl/ogce_req_check.sv
// ============================================================================
// ogce_req_check
// Sorts line endpoints, checks screen bounds and sets the byte count of one
// request.
// ============================================================================
module ogce_req_check import ogce_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic [2:0]  opcode,
  input  logic [7:0]  start_col,
  input  logic [7:0]  start_row,
  input  logic [7:0]  end_col,
  input  logic [7:0]  end_row,
  input  logic [15:0] pen_rgb,
  input  logic [15:0] fill_rgb,
  output req_t        req
);

  localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
  localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);

  logic       col_swap;
  logic       row_swap;
  logic [7:0] lc0;
  logic [7:0] lc1;
  logic [7:0] lr0;
  logic [7:0] lr1;
  logic       box_in;
  logic       pix_in;

  assign col_swap = end_col < start_col;
  assign row_swap = end_row < start_row;
  assign lc0 = col_swap ? end_col   : start_col;
  assign lc1 = col_swap ? start_col : end_col;
  assign lr0 = row_swap ? end_row   : start_row;
  assign lr1 = row_swap ? start_row : end_row;

  assign box_in = ({1'b0, start_col} < WIDTH_LIM)  && ({1'b0, end_col} < WIDTH_LIM) &&
                  ({1'b0, start_row} < HEIGHT_LIM) && ({1'b0, end_row} < HEIGHT_LIM);
  assign pix_in = ({1'b0, start_col} < WIDTH_LIM) && ({1'b0, start_row} < HEIGHT_LIM);

  always_comb begin
    req.op   = op_t'(opcode);
    req.c0   = start_col;
    req.r0   = start_row;
    req.c1   = end_col;
    req.r1   = end_row;
    req.pen  = pen_rgb;
    req.fill = fill_rgb;
    req.len  = '0;
    case (op_t'(opcode))
      OP_INIT: begin
        req.len = IDX_W'(INIT_LEN);
      end
      OP_LINE: begin
        req.c0  = lc0;
        req.r0  = lr0;
        req.c1  = lc1;
        req.r1  = lr1;
        req.len = box_in ? LINE_LEN : '0;
      end
      OP_RECT: begin
        req.len = box_in ? RECT_LEN : '0;
      end
      OP_CLEAR: begin
        req.len = CLEAR_LEN;
      end
      OP_PIXEL: begin
        req.len = pix_in ? PIXEL_LEN : '0;
      end
      default: begin
        req.len = '0;
      end
    endcase
  end

endmodule

>>> hdl/ogce_byte_sel.sv
// ============================================================================
// ogce_byte_sel
// Picks the byte at one position of a held request's run.
// ============================================================================
module ogce_byte_sel import ogce_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  req_t             req,
  input  logic [IDX_W-1:0] idx,
  output byte_t            word
);

  localparam logic [7:0] COL_END = 8'(SCREEN_WIDTH - 1);
  localparam logic [7:0] ROW_END = 8'(SCREEN_HEIGHT - 1);

  logic [7:0] coord;
  logic [7:0] pen_comp;
  logic [7:0] fill_comp;
  logic [7:0] val;
  logic       data;

  always_comb begin
    case (idx[1:0])
      2'd0:    coord = req.r1;
      2'd1:    coord = req.c0;
      2'd2:    coord = req.r0;
      default: coord = req.c1;
    endcase
  end

  always_comb begin
    case (idx)
      IDX_W'(7): pen_comp = colour_red(req.pen);
      IDX_W'(8): pen_comp = colour_green(req.pen);
      default:   pen_comp = colour_blue(req.pen);
    endcase
  end

  always_comb begin
    case (idx)
      IDX_W'(10): fill_comp = colour_red(req.fill);
      IDX_W'(11): fill_comp = colour_green(req.fill);
      default:    fill_comp = colour_blue(req.fill);
    endcase
  end

  always_comb begin
    val  = '0;
    data = 1'b0;
    case (req.op)
      OP_INIT: begin
        val = INIT_SEQ[idx];
      end
      OP_LINE: begin
        if (idx == '0) begin
          val = CMD_LINE;
        end else if (idx < IDX_W'(5)) begin
          val = coord;
        end else if (idx == IDX_W'(5)) begin
          val = colour_red(req.pen);
        end else if (idx == IDX_W'(6)) begin
          val = colour_green(req.pen);
        end else begin
          val = colour_blue(req.pen);
        end
      end
      OP_RECT: begin
        case (idx)
          IDX_W'(0): val = CMD_FILL;
          IDX_W'(1): val = FILL_ENABLE;
          IDX_W'(2): val = CMD_RECT;
          IDX_W'(3): val = req.c0;
          IDX_W'(4): val = req.r0;
          IDX_W'(5): val = req.c1;
          IDX_W'(6): val = req.r1;
          IDX_W'(7), IDX_W'(8), IDX_W'(9): val = pen_comp;
          default: val = fill_comp;
        endcase
      end
      OP_CLEAR: begin
        val = (idx == '0) ? CMD_CLEAR : coord;
      end
      OP_PIXEL: begin
        case (idx)
          IDX_W'(0): val = CMD_COL_ADDR;
          IDX_W'(1): val = req.c0;
          IDX_W'(2): val = COL_END;
          IDX_W'(3): val = CMD_ROW_ADDR;
          IDX_W'(4): val = req.r0;
          IDX_W'(5): val = ROW_END;
          IDX_W'(6): begin
            val  = req.pen[15:8];
            data = 1'b1;
          end
          default: begin
            val  = req.pen[7:0];
            data = 1'b1;
          end
        endcase
      end
      default: begin
        val = '0;
      end
    endcase
  end

  assign word.value   = val;
  assign word.is_data = data;
  assign word.last    = (idx == req.len - IDX_W'(1));

endmodule

>>> hdl/oled_graphics_command_encoder.sv
// ============================================================================
// oled_graphics_command_encoder
// Turns one drawing request into the byte run for an RGB565 OLED controller.
//
//   channel   handshake           payload
//   in_       in_valid/in_stall   opcode, coordinates, pen and fill colours
//   out_      out_valid/out_stall out_byte, is_data, last_byte
//
// One byte per cycle leaves the output register while out_stall is low; a
// request emits 37 bytes (init), 13 (rectangle), 8 (line, pixel) or 5 (clear),
// set by the single byte sequencer. The next request is taken in the cycle
// its predecessor's last byte is loaded. Requests that emit nothing are not
// held, so they raise no stall. Reset clears the valid flags and the byte index;
// a stall holds the output word and the sequencer.
// ============================================================================
module oled_graphics_command_encoder import ogce_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_start_col,
  input  logic [7:0]  in_start_row,
  input  logic [7:0]  in_end_col,
  input  logic [7:0]  in_end_row,
  input  logic [15:0] in_pen_rgb,
  input  logic [15:0] in_fill_rgb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last_byte
);

  req_t             chk_req;
  req_t             req_r;
  logic             req_valid_r;
  logic             req_valid_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  byte_t            sel_word;
  byte_t            out_r;
  logic             out_valid_r;
  logic             adv;
  logic             emit;
  logic             last_emit;
  logic             accept;

  ogce_req_check #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_check (
    .opcode    (in_opcode),
    .start_col (in_start_col),
    .start_row (in_start_row),
    .end_col   (in_end_col),
    .end_row   (in_end_row),
    .pen_rgb   (in_pen_rgb),
    .fill_rgb  (in_fill_rgb),
    .req       (chk_req)
  );

  ogce_byte_sel #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_sel (
    .req  (req_r),
    .idx  (idx_r),
    .word (sel_word)
  );

  assign adv       = !out_valid_r || !out_stall;
  assign emit      = req_valid_r && adv;
  assign last_emit = emit && sel_word.last;
  assign in_stall  = req_valid_r && !last_emit;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = req_valid_r;
    idx_nxt       = idx_r;
    if (accept) begin
      req_valid_nxt = (chk_req.len != '0);
      idx_nxt       = '0;
    end else if (last_emit) begin
      req_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      idx_r       <= idx_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= chk_req;
    end
    if (emit) begin
      out_r <= sel_word;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_r.value;
  assign out_is_data   = out_r.is_data;
  assign out_last_byte = out_r.last;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r |-> (idx_r < req_r.len))
    else $error("byte index beyond run length");

  a_run_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r |-> (req_r.len != '0))
    else $error("empty run held");

  a_accept_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (idx_r == '0))
    else $error("run did not restart on accept");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted word lost");

endmodule

>>> test/oled_graphics_command_encoder_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// oled_graphics_command_encoder_tb
// Drives drawing requests of every opcode into the encoder, from a directed
// set of corner cases and then random, mostly on-screen requests. Works out
// the byte run of each accepted request and compares every output word with
// the oldest expected one. Four phases vary sender idling and receiver stall.
// ============================================================================
module oled_graphics_command_encoder_tb;
  import ogce_pkg::*;

  localparam int SCREEN_W  = 96;
  localparam int SCREEN_H  = 64;
  localparam int SETUP_LEN = 37;
  localparam int PHASES    = 4;
  localparam int PHASE_ITEMS = 64;
  localparam int SEND_IDLE_PCT [PHASES] = '{0, 59, 0, 26};
  localparam int STALL_PCT [PHASES]     = '{0, 0, 59, 26};

  localparam logic [7:0] BYTE_LINE      = 8'h21;
  localparam logic [7:0] BYTE_RECT      = 8'h22;
  localparam logic [7:0] BYTE_CLEAR     = 8'h25;
  localparam logic [7:0] BYTE_FILL_MODE = 8'h26;
  localparam logic [7:0] BYTE_FILL_ON   = 8'h01;
  localparam logic [7:0] BYTE_COL_WIN   = 8'h15;
  localparam logic [7:0] BYTE_ROW_WIN   = 8'h75;

  localparam logic [7:0] SETUP_SEQ [SETUP_LEN] = '{
    8'hAE, 8'hA0, 8'h72, 8'hA1, 8'h00, 8'hA2, 8'h00, 8'hA4, 8'hA8, 8'h3F,
    8'hAD, 8'h8E, 8'hB0, 8'h0B, 8'hB1, 8'h31, 8'hB3, 8'hF0, 8'h8A, 8'h64,
    8'h8B, 8'h78, 8'h8C, 8'h64, 8'hBB, 8'h3A, 8'hBE, 8'h3E, 8'h87, 8'h06,
    8'h81, 8'h91, 8'h82, 8'h50, 8'h83, 8'h7D, 8'hAF
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  c0;
    logic [7:0]  r0;
    logic [7:0]  c1;
    logic [7:0]  r1;
    logic [15:0] pen;
    logic [15:0] fill;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       dc;
    logic       last;
  } coded_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [7:0]  in_start_col = '0;
  logic [7:0]  in_start_row = '0;
  logic [7:0]  in_end_col = '0;
  logic [7:0]  in_end_row = '0;
  logic [15:0] in_pen_rgb = '0;
  logic [15:0] in_fill_rgb = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_is_data;
  logic        out_last_byte;

  draw_req_t   request_q [$];
  coded_byte_t byte_q [$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          fail_count = 0;

  oled_graphics_command_encoder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_start_col (in_start_col),
    .in_start_row (in_start_row),
    .in_end_col   (in_end_col),
    .in_end_row   (in_end_row),
    .in_pen_rgb   (in_pen_rgb),
    .in_fill_rgb  (in_fill_rgb),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_is_data  (out_is_data),
    .out_last_byte(out_last_byte)
  );

  always #2 clk = ~clk;

  function automatic void put_byte(ref coded_byte_t run [$], input logic [7:0] v,
                                   input logic dc);
    coded_byte_t b;
    b.value = v;
    b.dc    = dc;
    b.last  = 1'b0;
    run.push_back(b);
  endfunction

  function automatic void put_colour(ref coded_byte_t run [$], input logic [15:0] c);
    put_byte(run, {2'b00, c[15:11], 1'b0}, 1'b0);
    put_byte(run, {2'b00, c[10:5]}, 1'b0);
    put_byte(run, {2'b00, c[4:0], 1'b0}, 1'b0);
  endfunction

  function automatic bit on_screen(input logic [7:0] c0, input logic [7:0] r0,
                                   input logic [7:0] c1, input logic [7:0] r1);
    return c0 < SCREEN_W && c1 < SCREEN_W && r0 < SCREEN_H && r1 < SCREEN_H;
  endfunction

  function automatic void encode_request(input draw_req_t r, ref coded_byte_t run [$]);
    logic [7:0] lo_c, hi_c, lo_r, hi_r;
    run.delete();
    lo_c = (r.c1 < r.c0) ? r.c1 : r.c0;
    hi_c = (r.c1 < r.c0) ? r.c0 : r.c1;
    lo_r = (r.r1 < r.r0) ? r.r1 : r.r0;
    hi_r = (r.r1 < r.r0) ? r.r0 : r.r1;
    case (r.opcode)
      OP_INIT: begin
        for (int i = 0; i < SETUP_LEN; i++) put_byte(run, SETUP_SEQ[i], 1'b0);
      end
      OP_LINE: begin
        if (on_screen(lo_c, lo_r, hi_c, hi_r)) begin
          put_byte(run, BYTE_LINE, 1'b0);
          put_byte(run, lo_c, 1'b0);
          put_byte(run, lo_r, 1'b0);
          put_byte(run, hi_c, 1'b0);
          put_byte(run, hi_r, 1'b0);
          put_colour(run, r.pen);
        end
      end
      OP_RECT: begin
        if (on_screen(r.c0, r.r0, r.c1, r.r1)) begin
          put_byte(run, BYTE_FILL_MODE, 1'b0);
          put_byte(run, BYTE_FILL_ON, 1'b0);
          put_byte(run, BYTE_RECT, 1'b0);
          put_byte(run, r.c0, 1'b0);
          put_byte(run, r.r0, 1'b0);
          put_byte(run, r.c1, 1'b0);
          put_byte(run, r.r1, 1'b0);
          put_colour(run, r.pen);
          put_colour(run, r.fill);
        end
      end
      OP_CLEAR: begin
        put_byte(run, BYTE_CLEAR, 1'b0);
        put_byte(run, r.c0, 1'b0);
        put_byte(run, r.r0, 1'b0);
        put_byte(run, r.c1, 1'b0);
        put_byte(run, r.r1, 1'b0);
      end
      OP_PIXEL: begin
        if (on_screen(r.c0, r.r0, r.c0, r.r0)) begin
          put_byte(run, BYTE_COL_WIN, 1'b0);
          put_byte(run, r.c0, 1'b0);
          put_byte(run, 8'(SCREEN_W - 1), 1'b0);
          put_byte(run, BYTE_ROW_WIN, 1'b0);
          put_byte(run, r.r0, 1'b0);
          put_byte(run, 8'(SCREEN_H - 1), 1'b0);
          put_byte(run, r.pen[15:8], 1'b1);
          put_byte(run, r.pen[7:0], 1'b1);
        end
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) r.opcode = OP_INIT;
    else if (pick < 28) r.opcode = OP_LINE;
    else if (pick < 50) r.opcode = OP_RECT;
    else if (pick < 70) r.opcode = OP_CLEAR;
    else if (pick < 94) r.opcode = OP_PIXEL;
    else r.opcode = 3'($urandom_range(7, OP_PIXEL + 1));
    if ($urandom_range(99) < 85) begin
      r.c0 = 8'($urandom_range(SCREEN_W - 1));
      r.c1 = 8'($urandom_range(SCREEN_W - 1));
      r.r0 = 8'($urandom_range(SCREEN_H - 1));
      r.r1 = 8'($urandom_range(SCREEN_H - 1));
    end else begin
      r.c0 = 8'($urandom);
      r.c1 = 8'($urandom);
      r.r0 = 8'($urandom);
      r.r1 = 8'($urandom);
    end
    r.pen  = 16'($urandom);
    r.fill = 16'($urandom);
    return r;
  endfunction

  task automatic queue_request(input logic [2:0] op, input logic [7:0] c0,
                               input logic [7:0] r0, input logic [7:0] c1,
                               input logic [7:0] r1, input logic [15:0] pen,
                               input logic [15:0] fill);
    draw_req_t r;
    r = '{op, c0, r0, c1, r1, pen, fill};
    request_q.push_back(r);
  endtask

  always @(posedge clk) begin : drive_requests
    draw_req_t   nxt;
    draw_req_t   taken;
    coded_byte_t run [$];
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken = '{in_opcode, in_start_col, in_start_row, in_end_col, in_end_row,
                  in_pen_rgb, in_fill_rgb};
        encode_request(taken, run);
        foreach (run[i]) byte_q.push_back(run[i]);
      end
      if (!in_valid || !in_stall) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_opcode    <= nxt.opcode;
          in_start_col <= nxt.c0;
          in_start_row <= nxt.r0;
          in_end_col   <= nxt.c1;
          in_end_row   <= nxt.r1;
          in_pen_rgb   <= nxt.pen;
          in_fill_rgb  <= nxt.fill;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    coded_byte_t exp_b;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (byte_q.size() == 0) begin
          $error("unexpected word: out_byte %0h", out_byte);
          fail_count++;
        end else begin
          exp_b = byte_q.pop_front();
          if (out_byte !== exp_b.value) begin
            $error("out_byte: expected %0h, got %0h", exp_b.value, out_byte);
            fail_count++;
          end
          if (out_is_data !== exp_b.dc) begin
            $error("out_is_data: expected %0b, got %0b", exp_b.dc, out_is_data);
            fail_count++;
          end
          if (out_last_byte !== exp_b.last) begin
            $error("out_last_byte: expected %0b, got %0b", exp_b.last, out_last_byte);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("oled_graphics_command_encoder_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    draw_req_t   r;
    coded_byte_t run [$];
    int          producing;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(OP_INIT, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000);
    queue_request(OP_LINE, 8'd95, 8'd63, 8'd0, 8'd0, 16'hFFFF, 16'h0000);
    queue_request(OP_LINE, 8'd0, 8'd63, 8'd95, 8'd0, 16'h0000, 16'hFFFF);
    queue_request(OP_LINE, 8'd10, 8'd5, 8'd20, 8'd40, 16'hA5A5, 16'h5A5A);
    queue_request(OP_LINE, 8'd96, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF);
    queue_request(OP_LINE, 8'd0, 8'd0, 8'd0, 8'd64, 16'hFFFF, 16'hFFFF);
    queue_request(OP_RECT, 8'd0, 8'd0, 8'd95, 8'd63, 16'hFFFF, 16'h0000);
    queue_request(OP_RECT, 8'd95, 8'd63, 8'd0, 8'd0, 16'h0000, 16'hFFFF);
    queue_request(OP_RECT, 8'd0, 8'd0, 8'd255, 8'd63, 16'h1234, 16'h5678);
    queue_request(OP_RECT, 8'd0, 8'd255, 8'd95, 8'd0, 16'h1234, 16'h5678);
    queue_request(OP_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    queue_request(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000);
    queue_request(OP_CLEAR, 8'd200, 8'd3, 8'd7, 8'd128, 16'h0000, 16'h0000);
    queue_request(OP_PIXEL, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    queue_request(OP_PIXEL, 8'd95, 8'd63, 8'd0, 8'd0, 16'h0000, 16'h0000);
    queue_request(OP_PIXEL, 8'd96, 8'd0, 8'd0, 8'd0, 16'hF800, 16'h0000);
    queue_request(OP_PIXEL, 8'd0, 8'd64, 8'd0, 8'd0, 16'h07E0, 16'h0000);
    queue_request(OP_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 16'h001F, 16'h0000);
    for (int k = OP_PIXEL + 1; k < 8; k++)
      queue_request(3'(k), 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
    queue_request(OP_INIT, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      stall_pct     = STALL_PCT[p];
      producing = 0;
      while (producing < PHASE_ITEMS) begin
        r = random_request();
        encode_request(r, run);
        if (run.size() > 0) producing++;
        request_q.push_back(r);
      end
      while (request_q.size() != 0 || in_valid || byte_q.size() != 0) @(posedge clk);
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("oled_graphics_command_encoder_tb: PASS");
    end else begin
      $display("oled_graphics_command_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule
